[rtl/b64d_pkg.sv]
// b64d_pkg: types, constants and helper functions of the base64 stream decoder.
// Standalone; used by every module of the decoder under rtl/.
package b64d_pkg;

	localparam logic [7:0] CHAR_PAD   = 8'h3d;  // '='
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;  // '+'
	localparam logic [7:0] CHAR_SLASH = 8'h2f;  // '/'
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;

	// Offsets that move a character into its sextet range (mod 256).
	localparam logic [7:0] OFS_LOWER = 8'd71;  // 'a' - 26
	localparam logic [7:0] OFS_DIGIT = 8'd4;   // 52 - '0'

	// Bytes decoded from one input item, ready for the back end.
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] cnt;  // 1..3 bytes valid
	} b64d_rec_t;

	typedef struct packed {
		logic ok;
		logic [5:0] val;
	} b64d_map_t;

	function automatic b64d_map_t map_char(input logic [7:0] c);
		b64d_map_t r;
		logic [7:0] t;
		r.ok = 1'b1;
		r.val = '0;
		t = '0;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			t = c - CHAR_UPPER_A;
			r.val = t[5:0];
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			t = c - OFS_LOWER;
			r.val = t[5:0];
		end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
			t = c + OFS_DIGIT;
			r.val = t[5:0];
		end else if (c == CHAR_PLUS) begin
			r.val = SEXTET_PLUS;
		end else if (c == CHAR_SLASH) begin
			r.val = SEXTET_SLASH;
		end else begin
			r.ok = 1'b0;  // '=' and every other byte stop decoding
		end
		return r;
	endfunction

	function automatic logic [23:0] pack_group(input logic [5:0] s0, input logic [5:0] s1,
		input logic [5:0] s2, input logic [5:0] s3);
		return {s0, s1, s2, s3};
	endfunction

endpackage

[rtl/base64_stream_decoder.sv]
// Streaming base64 decoder: one character per item in, one decoded byte per item out.
// Characters are taken one per cycle while the output side keeps up; a group of four
// characters yields three bytes, and the byte output runs at one byte per cycle, so a
// clean stream sustains one character per cycle. Bytes pass the record queue, then
// the output register. The front end stalls only when the QUEUE_DEPTH-entry record
// queue between front and back end is full; a stop or end-of-string flush adds up to
// two bytes, which the queue absorbs. last_in_run marks the final byte produced by one
// input character. Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
module base64_stream_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_in_run
);

	logic                q_full;
	logic                push;
	b64d_pkg::b64d_rec_t push_rec;
	logic                pop;
	logic                head_valid;
	b64d_pkg::b64d_rec_t head_rec;

	b64d_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_char       (in_char),
		.end_of_string (end_of_string),
		.q_full        (q_full),
		.push          (push),
		.push_rec      (push_rec)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	b64d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_rec    (head_rec),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_in_run (last_in_run)
	);

endmodule

[rtl/b64d_front.sv]
// b64d_front: accepts characters, maps them to sextets, tracks the open group
// and produces at most one record of decoded bytes per item. Uses b64d_pkg.
module b64d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_char,
	input  logic                end_of_string,
	input  logic                q_full,
	output logic                push,
	output b64d_pkg::b64d_rec_t push_rec
);

	logic [5:0] buf_q [3];
	logic [1:0] fill_q;
	logic       halted_q;

	b64d_pkg::b64d_map_t m;
	logic       accept;
	logic [5:0] s0, s1, s2, s3;
	logic [23:0] grp;
	logic [1:0] cnt;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign m        = b64d_pkg::map_char(in_char);

	// Group as it stands with the new sextet placed after the held ones.
	always_comb begin
		s0 = (fill_q == 2'd0) ? m.val : buf_q[0];
		s1 = (fill_q >  2'd1) ? buf_q[1] : ((fill_q == 2'd1) ? m.val : 6'd0);
		s2 = (fill_q == 2'd3) ? buf_q[2] : ((fill_q == 2'd2) ? m.val : 6'd0);
		s3 = (fill_q == 2'd3) ? m.val : 6'd0;
		grp = b64d_pkg::pack_group(s0, s1, s2, s3);
	end

	always_comb begin
		cnt = 2'd0;
		if (!halted_q) begin
			if (m.ok) begin
				if (fill_q == 2'd3) begin
					cnt = 2'd3;
				end else if (end_of_string) begin
					cnt = fill_q;  // k held plus this one gives k bytes
				end
			end else if (fill_q > 2'd1) begin
				cnt = fill_q - 2'd1;
			end
		end
	end

	assign push         = accept && (cnt != 2'd0);
	assign push_rec.b0  = grp[23:16];
	assign push_rec.b1  = grp[15:8];
	assign push_rec.b2  = grp[7:0];
	assign push_rec.cnt = cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= 2'd0;
			halted_q <= 1'b0;
		end else if (accept) begin
			if (end_of_string) begin
				fill_q   <= 2'd0;
				halted_q <= 1'b0;
			end else if (!halted_q) begin
				if (m.ok) begin
					fill_q <= fill_q + 2'd1;  // wraps to zero on a full group
				end else begin
					fill_q   <= 2'd0;
					halted_q <= 1'b1;
				end
			end
		end
	end

	// Sextet slots are read only below the fill count.
	always_ff @(posedge clk) begin
		if (accept && !halted_q && m.ok) begin
			case (fill_q)
				2'd0: buf_q[0] <= m.val;
				2'd1: buf_q[1] <= m.val;
				2'd2: buf_q[2] <= m.val;
				default: ;
			endcase
		end
	end

endmodule

[rtl/b64d_queue.sv]
// b64d_queue: short FIFO of decoded-byte records between front and back end.
// Uses b64d_pkg for the record type.
module b64d_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b64d_pkg::b64d_rec_t push_rec,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output b64d_pkg::b64d_rec_t head_rec
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

	b64d_pkg::b64d_rec_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == DEPTH_CNT);
	assign head_valid = (count_q != '0);
	assign head_rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT) else $error("queue count out of range");
	a_rec_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_rec.cnt != 2'd0) else $error("empty record queued");

endmodule

[rtl/b64d_back.sv]
// b64d_back: sends the bytes of the queue's head record one per cycle while
// out_ready allows, via an output register. Uses b64d_pkg for record types.
module b64d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  b64d_pkg::b64d_rec_t head_rec,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                last_in_run
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic [1:0] idx_q;

	logic       load;
	logic       last_byte;
	logic [7:0] sel_byte;

	assign load      = head_valid && (!out_valid_q || out_ready);
	assign last_byte = (idx_q == (head_rec.cnt - 2'd1));
	assign pop       = load && last_byte;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head_rec.b0;
			2'd1:    sel_byte = head_rec.b1;
			default: sel_byte = head_rec.b2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last_byte ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= sel_byte;
			last_q     <= last_byte;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_in_run = last_q;

	a_idx_in_rec: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q < head_rec.cnt) else $error("byte index past record");
	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid && last_in_run) else $error("record retired without last byte");
	a_idx_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> idx_q == 2'd0) else $error("byte index left open");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking testbench for base64_stream_decoder, with randomized idling on both sides.
// Depends on b64d_pkg and the decoder RTL under rtl/; needs no other file.
module tb_top;

	localparam int RANDOM_CHARS = 350;
	localparam int STUCK_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_char;
	logic       end_of_string;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       last_in_run;

	typedef struct {
		bit [7:0] value;
		bit       last;
	} decoded_byte_t;

	// Tracks the decoder state and holds the bytes still owed by the block.
	class b64_scoreboard;
		bit [5:0]      sextets[3];
		bit [1:0]      fill;
		bit            halted;
		decoded_byte_t bytes_due[$];
		int            checked;
		int            errors;

		function bit lookup_sextet(input bit [7:0] c, output bit [5:0] v);
			bit [7:0] t;
			t = '0;
			lookup_sextet = 1'b1;
			if (c >= b64d_pkg::CHAR_UPPER_A && c <= b64d_pkg::CHAR_UPPER_Z) begin
				t = c - b64d_pkg::CHAR_UPPER_A;
			end else if (c >= b64d_pkg::CHAR_LOWER_A && c <= b64d_pkg::CHAR_LOWER_Z) begin
				t = c - b64d_pkg::CHAR_LOWER_A + 8'd26;
			end else if (c >= b64d_pkg::CHAR_DIGIT_0 && c <= b64d_pkg::CHAR_DIGIT_9) begin
				t = c - b64d_pkg::CHAR_DIGIT_0 + 8'd52;
			end else if (c == b64d_pkg::CHAR_PLUS) begin
				t = 8'd62;
			end else if (c == b64d_pkg::CHAR_SLASH) begin
				t = 8'd63;
			end else begin
				lookup_sextet = 1'b0;
			end
			v = t[5:0];
		endfunction

		function void emit(input bit [5:0] s0, input bit [5:0] s1, input bit [5:0] s2,
			input bit [5:0] s3, input int count, ref bit [7:0] run[$]);
			bit [7:0] b[3];
			b[0] = {s0, s1[5:4]};
			b[1] = {s1[3:0], s2[5:2]};
			b[2] = {s2[1:0], s3};
			for (int i = 0; i < count; i++)
				run = {run, b[i]};
		endfunction

		// A partial group of k sextets gives k-1 bytes; missing sextets read as zero.
		function void flush_group(ref bit [7:0] run[$]);
			if (fill > 2'd1)
				emit(sextets[0], sextets[1], (fill == 2'd3) ? sextets[2] : 6'd0, 6'd0,
					int'(fill) - 1, run);
		endfunction

		function void decode_char(input bit [7:0] c, input bit eos);
			bit [7:0]      run[$];
			bit [5:0]      v;
			decoded_byte_t d;
			if (!halted) begin
				if (lookup_sextet(c, v)) begin
					if (fill == 2'd3) begin
						emit(sextets[0], sextets[1], sextets[2], v, 3, run);
						sextets = '{default: '0};
						fill = '0;
					end else begin
						sextets[fill] = v;
						fill++;
					end
					if (eos)
						flush_group(run);
				end else begin
					flush_group(run);
					sextets = '{default: '0};
					fill = '0;
					halted = 1'b1;
				end
			end
			if (eos) begin
				sextets = '{default: '0};
				fill = '0;
				halted = 1'b0;
			end
			foreach (run[i]) begin
				d.value = run[i];
				d.last = (i == run.size() - 1);
				bytes_due = {bytes_due, d};
			end
		endfunction

		function void check_byte(input logic [7:0] b, input logic last);
			decoded_byte_t d;
			if (bytes_due.size() == 0) begin
				$error("out_byte: nothing expected, got 8'h%02h (last_in_run %b)", b, last);
				errors++;
				return;
			end
			d = bytes_due.pop_front();
			checked++;
			if (b !== d.value) begin
				$error("out_byte: expected 8'h%02h, got 8'h%02h", d.value, b);
				errors++;
			end
			if (last !== d.last) begin
				$error("last_in_run: expected %b, got %b", d.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return bytes_due.size();
		endfunction
	endclass

	b64_scoreboard sb;
	int chars_sent;
	int strings_sent;
	int stuck_cycles;
	bit no_gaps;

	base64_stream_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_char      (in_char),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.last_in_run  (last_in_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit [7:0] sextet_to_char(input bit [5:0] s);
		if (s < 6'd26)
			return b64d_pkg::CHAR_UPPER_A + 8'(s);
		if (s < 6'd52)
			return b64d_pkg::CHAR_LOWER_A + 8'(s - 6'd26);
		if (s < 6'd62)
			return b64d_pkg::CHAR_DIGIT_0 + 8'(s - 6'd52);
		return (s == 6'd62) ? b64d_pkg::CHAR_PLUS : b64d_pkg::CHAR_SLASH;
	endfunction

	// Hold the item until accepted; an idle gap, if any, comes before it.
	task automatic send_char(input bit [7:0] c, input bit eos);
		int gap;
		int r;
		gap = 0;
		if (!no_gaps) begin
			r = $urandom_range(0, 99);
			if (r >= 92)
				gap = $urandom_range(10, 40);
			else if (r >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_char <= c;
		end_of_string <= eos;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.decode_char(c, eos);
		chars_sent++;
		if (eos)
			strings_sent++;
	endtask

	task automatic send_text(input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], close && (i == s.len() - 1));
	endtask

	initial begin
		int       n;
		int       kind;
		bit [7:0] c;
		bit [5:0] v;
		bit [7:0] str[$];
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_char = '0;
		end_of_string = 1'b0;
		no_gaps = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("TWFu", 1'b1);      // end on a full group: three bytes only
		send_text("TWE=", 1'b1);      // pad stops with three sextets held
		send_text("TQ==", 1'b1);      // second pad is ignored while halted
		send_text("A", 1'b1);         // lone character gives nothing
		send_text("Zz9", 1'b1);       // end flushes a three-sextet group
		send_text("+/09azAZ", 1'b0);
		send_char(8'hff, 1'b0);       // stop on an empty group
		send_char(8'h80, 1'b0);
		send_char(8'h00, 1'b1);

		while (chars_sent < RANDOM_CHARS) begin
			kind = $urandom_range(0, 9);
			no_gaps = ($urandom_range(0, 3) == 0);
			str.delete();
			if (kind <= 6) begin
				n = $urandom_range(0, 14);
				repeat (n) str = {str, sextet_to_char(6'($urandom_range(0, 63)))};
				if (n % 4 == 2 && $urandom_range(0, 1)) begin
					str = {str, b64d_pkg::CHAR_PAD};
					str = {str, b64d_pkg::CHAR_PAD};
				end else if (n % 4 == 3 && $urandom_range(0, 1)) begin
					str = {str, b64d_pkg::CHAR_PAD};
				end
				if ($urandom_range(0, 7) == 0)
					str = {str, 8'($urandom_range(0, 255))};
				if (str.size() == 0)
					str = {str, sextet_to_char(6'($urandom_range(0, 63)))};
			end else if (kind <= 8) begin
				// broken string: some sextets, a stray byte, then trailing junk
				n = $urandom_range(0, 7);
				repeat (n) str = {str, sextet_to_char(6'($urandom_range(0, 63)))};
				do c = 8'($urandom_range(0, 255)); while (sb.lookup_sextet(c, v));
				str = {str, c};
				repeat ($urandom_range(0, 4)) str = {str, 8'($urandom_range(0, 255))};
			end else begin
				repeat ($urandom_range(1, 6)) str = {str, 8'($urandom_range(0, 255))};
			end
			foreach (str[i])
				send_char(str[i], i == str.size() - 1);
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters in %0d strings (clean, padded, broken and noise).",
			chars_sent, strings_sent);
		$display("Checked %0d decoded bytes, %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Output side: ready runs broken by stalls, mostly short, a few long.
	initial begin
		int run_len;
		int stall;
		int r;
		out_ready = 1'b0;
		@(posedge clk);
		forever begin
			run_len = $urandom_range(1, 24);
			out_ready <= 1'b1;
			repeat (run_len) @(posedge clk);
			r = $urandom_range(0, 99);
			stall = 0;
			if (r >= 92)
				stall = $urandom_range(10, 50);
			else if (r >= 45)
				stall = $urandom_range(1, 3);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_byte(out_byte, last_in_run);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles, %0d bytes still owed.",
				STUCK_LIMIT, sb.pending());
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule

[base64_stream_decoder.f]
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder.sv
test/tb_top.sv
